// ----- sv/integer_to_radix_digits_core_macros.svh -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core assertion macros
// Shared property wrappers for the checker of the radix conversion core.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_CORE_MACROS_SVH

// checked on every clock edge outside reset
`define IXR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define IXR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/ixr_pkg.sv -----
// ----------------------------------------------------------------------------
// ixr_pkg
// Types, constants and the digit character map of the radix conversion core.
// ----------------------------------------------------------------------------
package ixr_pkg;

  localparam int VALUE_W           = 64;
  localparam int RADIX_W           = 6;
  localparam int ROOM_W            = 7;
  localparam int CHAR_W            = 7;
  localparam int DIGIT_W           = RADIX_W;
  localparam int DIGIT_STORE_DEPTH = 64;
  localparam int ADDR_W            = $clog2(DIGIT_STORE_DEPTH);
  localparam int CNT_W             = $clog2(DIGIT_STORE_DEPTH + 1);
  localparam int CMP_W             = (CNT_W > ROOM_W) ? CNT_W : ROOM_W;
  localparam int BITCNT_W          = $clog2(VALUE_W);

  localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(36);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA = CHAR_W'(55);  // 'A' minus ten
  localparam logic [CHAR_W-1:0]  CHAR_NONE  = CHAR_W'(0);
  localparam logic               STATUS_OK  = 1'b0;
  localparam logic               STATUS_ERR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_EMIT,
    ST_ERR
  } ixr_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic [ROOM_W-1:0]  room;
  } ixr_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
    logic              status;
  } ixr_result_t;

  typedef struct packed {
    logic load;
    logic again;
  } ixr_div_ctl_t;

  typedef struct packed {
    logic               done;
    logic               quot_nz;
    logic [DIGIT_W-1:0] digit;
  } ixr_div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (d < DIGIT_W'(36)) begin
      c = CHAR_ALPHA + CHAR_W'(d);
    end else begin
      c = CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

// ----- sv/ixr_divider.sv -----
// ----------------------------------------------------------------------------
// ixr_divider
// Bit-serial restoring divider: one quotient bit per cycle, the quotient
// stays in the shift register so the next digit can start right away.
// ----------------------------------------------------------------------------
module ixr_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  ixr_pkg::ixr_div_ctl_t        ctl,
  input  logic [ixr_pkg::VALUE_W-1:0]  value,
  input  logic [ixr_pkg::RADIX_W-1:0]  radix,
  output ixr_pkg::ixr_div_stat_t       stat
);

  logic                          active;
  logic [ixr_pkg::VALUE_W-1:0]   sr;
  logic [ixr_pkg::RADIX_W-1:0]   rem;
  logic [ixr_pkg::RADIX_W-1:0]   radix_r;
  logic [ixr_pkg::BITCNT_W-1:0]  bitcnt;
  logic                          qnz;

  logic [ixr_pkg::RADIX_W:0]     cat;
  logic [ixr_pkg::RADIX_W:0]     diff;
  logic                          ge;
  logic [ixr_pkg::RADIX_W-1:0]   rem_next;
  logic                          last_bit;

  always_comb begin
    cat      = {rem, sr[ixr_pkg::VALUE_W-1]};
    ge       = cat >= {1'b0, radix_r};
    diff     = cat - {1'b0, radix_r};
    // remainder stays below the radix, so it fits the narrow register
    rem_next = ge ? diff[ixr_pkg::RADIX_W-1:0] : cat[ixr_pkg::RADIX_W-1:0];
    last_bit = active && (bitcnt == ixr_pkg::BITCNT_W'(ixr_pkg::VALUE_W - 1));
    stat.done    = last_bit;
    stat.quot_nz = qnz | ge;
    stat.digit   = rem_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctl.load) begin
      active <= 1'b1;
    end else if (last_bit) begin
      active <= ctl.again;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sr      <= value;
      rem     <= '0;
      bitcnt  <= '0;
      qnz     <= 1'b0;
      radix_r <= radix;
    end else if (active) begin
      sr     <= {sr[ixr_pkg::VALUE_W-2:0], ge};
      bitcnt <= bitcnt + ixr_pkg::BITCNT_W'(1);
      if (last_bit) begin
        // next digit divides the quotient just formed
        rem <= '0;
        qnz <= 1'b0;
      end else begin
        rem <= rem_next;
        qnz <= qnz | ge;
      end
    end
  end

endmodule

// ----- sv/integer_to_radix_digits_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core
// Converts an unsigned 64-bit value to ASCII digits in radix 2 to 36.
// ----------------------------------------------------------------------------
// A conversion is taken when start is high while busy is low. The value is
// divided by the radix over and over in a bit-serial divider that forms one
// quotient bit per cycle; the digits go into a small store, least
// significant first, and are then sent out most significant first, one per
// cycle, each marked by strobe for a single cycle, the final one with last
// set. The receiver cannot stall the output. A bad radix or zero room gives
// one error result in the cycle after start; room too small gives the error
// result once all digits are formed. Zero converts as the single digit '0'.
module integer_to_radix_digits_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ixr_pkg::ixr_item_t    operand,
  output logic                  busy,
  output logic                  strobe,
  output ixr_pkg::ixr_result_t  result
);

  ixr_pkg::ixr_state_t          state;
  ixr_pkg::ixr_state_t          state_next;
  logic [ixr_pkg::ROOM_W-1:0]   room_r;
  logic [ixr_pkg::CNT_W-1:0]    count;
  logic [ixr_pkg::CNT_W-1:0]    cnt_inc;
  logic [ixr_pkg::ADDR_W-1:0]   pos;
  logic [ixr_pkg::DIGIT_W-1:0]  mem [ixr_pkg::DIGIT_STORE_DEPTH];
  logic [ixr_pkg::DIGIT_W-1:0]  rd_data;
  logic                         mem_we;
  logic                         bad_req;
  logic                         depth_full;
  logic                         room_short;
  ixr_pkg::ixr_div_ctl_t        div_ctl;
  ixr_pkg::ixr_div_stat_t       div_stat;

  ixr_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .ctl   (div_ctl),
    .value (operand.value),
    .radix (operand.radix),
    .stat  (div_stat)
  );

  always_comb begin
    bad_req    = (operand.room == '0) || (operand.radix < ixr_pkg::RADIX_MIN) ||
                 (operand.radix > ixr_pkg::RADIX_MAX);
    cnt_inc    = count + ixr_pkg::CNT_W'(1);
    depth_full = cnt_inc >= ixr_pkg::CNT_W'(ixr_pkg::DIGIT_STORE_DEPTH);
    // digits plus terminator must fit the room
    room_short = ixr_pkg::CMP_W'(cnt_inc) >= ixr_pkg::CMP_W'(room_r);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ixr_pkg::ST_IDLE: begin
        if (start) begin
          state_next = bad_req ? ixr_pkg::ST_ERR : ixr_pkg::ST_DIV;
        end
      end
      ixr_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if (div_stat.quot_nz) begin
            state_next = depth_full ? ixr_pkg::ST_ERR : ixr_pkg::ST_DIV;
          end else begin
            state_next = room_short ? ixr_pkg::ST_ERR : ixr_pkg::ST_PREP;
          end
        end
      end
      ixr_pkg::ST_PREP: begin
        state_next = ixr_pkg::ST_EMIT;
      end
      ixr_pkg::ST_EMIT: begin
        if (count == ixr_pkg::CNT_W'(1)) begin
          state_next = ixr_pkg::ST_IDLE;
        end
      end
      ixr_pkg::ST_ERR: begin
        state_next = ixr_pkg::ST_IDLE;
      end
      default: begin
        state_next = ixr_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy              = 1'b1;
    strobe            = 1'b0;
    result.digit_char = ixr_pkg::CHAR_NONE;
    result.last       = 1'b0;
    result.status     = ixr_pkg::STATUS_OK;
    div_ctl.load      = 1'b0;
    div_ctl.again     = 1'b0;
    mem_we            = 1'b0;
    case (state)
      ixr_pkg::ST_IDLE: begin
        busy         = 1'b0;
        div_ctl.load = start && !bad_req;
      end
      ixr_pkg::ST_DIV: begin
        mem_we        = div_stat.done;
        div_ctl.again = div_stat.done && div_stat.quot_nz && !depth_full;
      end
      ixr_pkg::ST_PREP: begin
        busy = 1'b1;
      end
      ixr_pkg::ST_EMIT: begin
        strobe            = 1'b1;
        result.digit_char = ixr_pkg::digit_to_char(rd_data);
        result.last       = count == ixr_pkg::CNT_W'(1);
      end
      ixr_pkg::ST_ERR: begin
        strobe        = 1'b1;
        result.last   = 1'b1;
        result.status = ixr_pkg::STATUS_ERR;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ixr_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        ixr_pkg::ST_IDLE: begin
          if (start) begin
            count <= '0;
          end
        end
        ixr_pkg::ST_DIV: begin
          if (div_stat.done) begin
            count <= cnt_inc;
          end
        end
        ixr_pkg::ST_EMIT: begin
          count <= count - ixr_pkg::CNT_W'(1);
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ixr_pkg::ST_IDLE && start) begin
      room_r <= operand.room;
    end
    if (state == ixr_pkg::ST_DIV && div_stat.done) begin
      // most significant digit sits at the slot just written
      pos <= count[ixr_pkg::ADDR_W-1:0];
    end else if (state == ixr_pkg::ST_PREP || state == ixr_pkg::ST_EMIT) begin
      pos <= pos - ixr_pkg::ADDR_W'(1);
    end
  end

  // digit store, registered read in the cycle before the transfer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[ixr_pkg::ADDR_W-1:0]] <= div_stat.digit;
    end
    rd_data <= mem[pos];
  end

endmodule

// ----- sv/ixr_checker.sv -----
// ----------------------------------------------------------------------------
// ixr_checker
// Port-level checks of the radix conversion core, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_core_macros.svh"

module ixr_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  strobe,
  input ixr_pkg::ixr_result_t  result
);

  `IXR_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted conversion did not raise busy")

  `IXR_ASSERT_ALWAYS(a_strobe_busy, strobe |-> busy, "result transfer while idle")

  `IXR_ASSERT(a_last_done, (strobe && result.last) |=> !busy, "busy held after final transfer")

  `IXR_ASSERT(a_err_form, (strobe && result.status) |-> (result.last && result.digit_char == ixr_pkg::CHAR_NONE), "malformed error result")

  `IXR_ASSERT(a_char_range, (strobe && !result.status) |-> ((result.digit_char >= 7'd48 && result.digit_char <= 7'd57) || (result.digit_char >= 7'd65 && result.digit_char <= 7'd90)), "digit character out of range")

endmodule

bind integer_to_radix_digits_core ixr_checker u_ixr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
